### hw/rtl/assert_macros.svh
// Assertion macros shared by the posting list decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define PLD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define PLD_ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define PLD_ASSERT(name, prop, msg)
`define PLD_ASSERT_NEVER(name, expr, msg)
`endif
`endif

### hw/rtl/pld_pkg.sv
// Types, codes and helpers of the posting list decoder.
`default_nettype none

package pld_pkg;

  localparam logic [1:0] KIND_FIXED    = 2'd0;
  localparam logic [1:0] KIND_VAR_HDR  = 2'd1;
  localparam logic [1:0] KIND_POSITION = 2'd2;
  localparam logic [1:0] KIND_ERROR    = 2'd3;

  localparam logic [1:0] LEN_CODE_ERROR = 2'd3;

  typedef struct packed {
    logic        have;
    logic [1:0]  kind;
    logic [27:0] doc_id;
    logic [31:0] entry_value;
    logic [13:0] position;
    logic [32:0] area_bytes;
    logic        list_done;
  } pld_result_t;

  // Number of value bytes for a size code: 1 one byte, 2 two bytes, 3 four bytes.
  function automatic logic [2:0] value_size(logic [1:0] code);
    logic [2:0] size;
    case (code)
      2'd1:    size = 3'd1;
      2'd2:    size = 3'd2;
      default: size = 3'd4;
    endcase
    return size;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/pld_if.sv
// Valid/ready channel interfaces of the posting list decoder.
`default_nettype none

interface pld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_list;

  modport source (output valid, output data_byte, output end_of_list, input ready);
  modport sink   (input valid, input data_byte, input end_of_list, output ready);
endinterface

interface pld_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [27:0]        doc_id;
  logic signed [31:0] entry_value;
  logic [13:0]        position;
  logic [32:0]        area_bytes;
  logic               list_done;

  modport source (output valid, output kind, output doc_id, output entry_value,
                  output position, output area_bytes, output list_done, input ready);
  modport sink   (input valid, input kind, input doc_id, input entry_value,
                  input position, input area_bytes, input list_done, output ready);
endinterface

`default_nettype wire

### hw/rtl/posting_list_decoder.sv
// Posting list decoder top level: input stage, parser and result register.
//
// The block takes a compressed posting list one byte per beat on in_i (data_byte
// and end_of_list, the latter set on the final byte of a list) and delivers
// decoded records on out_o: fixed entries, variable entry headers, position
// records and format errors. A byte yields zero or one record.
// A byte accepted into the input stage register is parsed from there, and
// its record is loaded into the output register, from which it is taken.
// Throughput: one byte per cycle while the receiver takes records; the parse
// state is updated by a single step of combinational logic between the input
// register and the parser registers, so a new byte can enter every cycle.
// When the receiver stalls, the record waits in the output register; one
// more byte is held in the input stage, and bytes that make no record still
// pass through the parser. Input ready drops only when both stages are full.
// Reset clears both stages and puts the parser at the start of a group id.
`default_nettype none
`include "assert_macros.svh"

module posting_list_decoder (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pld_in_if.sink     in_i,
  pld_out_if.source  out_o
);

  logic                 s1_valid_q;
  logic [7:0]           s1_byte_q;
  logic                 s1_eol_q;
  logic                 s1_adv;
  logic                 in_ready;
  logic                 out_valid_q;
  pld_pkg::pld_result_t core_res;
  pld_pkg::pld_result_t out_q;

  pld_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_adv),
    .byte_i (s1_byte_q),
    .eol_i  (s1_eol_q),
    .res_o  (core_res)
  );

  // A byte leaves the input stage unless its record would overwrite a stalled one.
  assign s1_adv   = s1_valid_q && (!core_res.have || !out_valid_q || out_o.ready);
  assign in_ready = !s1_valid_q || s1_adv;
  assign in_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_i.valid) begin
      s1_byte_q <= in_i.data_byte;
      s1_eol_q  <= in_i.end_of_list;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && core_res.have) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && core_res.have) begin
      out_q <= core_res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = out_q.kind;
  assign out_o.doc_id      = out_q.doc_id;
  assign out_o.entry_value = out_q.entry_value;
  assign out_o.position    = out_q.position;
  assign out_o.area_bytes  = out_q.area_bytes;
  assign out_o.list_done   = out_q.list_done;

  `PLD_ASSERT(a_record_loaded, s1_adv && core_res.have |=> out_valid_q, "parsed record was not registered")
  `PLD_ASSERT(a_stall_cause, !in_ready |-> s1_valid_q && out_valid_q, "input stalled without both stages full")
  `PLD_ASSERT(a_s1_hold, s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_byte_q), "held input byte was lost")

endmodule

`default_nettype wire

### hw/rtl/pld_core.sv
// Parse state of the posting list decoder and its per-byte next-state logic.
`default_nettype none
`include "assert_macros.svh"

module pld_core (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire logic [7:0]        byte_i,
  input  wire logic              eol_i,
  output pld_pkg::pld_result_t   res_o
);

  typedef enum logic [11:0] {
    PH_GID_LO   = 12'b0000_0000_0001,
    PH_GID_HI   = 12'b0000_0000_0010,
    PH_LEN0     = 12'b0000_0000_0100,
    PH_LEN_MORE = 12'b0000_0000_1000,
    PH_ENT_LO   = 12'b0000_0001_0000,
    PH_ENT_HI   = 12'b0000_0010_0000,
    PH_FIX_VAL  = 12'b0000_0100_0000,
    PH_AREA_LEN = 12'b0000_1000_0000,
    PH_POS_LO   = 12'b0001_0000_0000,
    PH_POS_HI   = 12'b0010_0000_0000,
    PH_POS_VAL  = 12'b0100_0000_0000,
    PH_DRAIN    = 12'b1000_0000_0000
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] group_base_q, group_base_d;
  logic [21:0] group_left_q, group_left_d;
  logic [32:0] area_left_q, area_left_d;
  logic [31:0] assembly_q, assembly_d;
  logic [2:0]  byte_count_q, byte_count_d;
  logic [11:0] entry_low_id_q, entry_low_id_d;
  logic [2:0]  value_code_q, value_code_d;
  logic [13:0] pos_hold_q, pos_hold_d;

  logic [21:0] gl_dec;
  logic [21:0] gl_len;
  logic [32:0] al_dec;
  logic [31:0] asm_col;
  logic [2:0]  bc_inc;
  logic [15:0] word;
  logic [3:0]  ent_code;
  logic        fail;
  logic        start;
  logic [32:0] area_cnt;
  logic        have;
  logic [1:0]  kind;
  logic [31:0] val;
  logic [13:0] pos;
  logic [32:0] area;

  always_comb begin
    phase_d        = phase_q;
    group_base_d   = group_base_q;
    group_left_d   = group_left_q;
    area_left_d    = area_left_q;
    assembly_d     = assembly_q;
    byte_count_d   = byte_count_q;
    entry_low_id_d = entry_low_id_q;
    value_code_d   = value_code_q;
    pos_hold_d     = pos_hold_q;

    have     = 1'b0;
    kind     = pld_pkg::KIND_FIXED;
    val      = '0;
    pos      = '0;
    area     = '0;
    fail     = 1'b0;
    start    = 1'b0;
    area_cnt = '0;

    gl_dec   = group_left_q - 22'd1;
    al_dec   = area_left_q - 33'd1;
    asm_col  = assembly_q | ({24'b0, byte_i} << {byte_count_q[1:0], 3'b000});
    bc_inc   = byte_count_q + 3'd1;
    word     = {byte_i, assembly_q[7:0]};
    ent_code = assembly_q[3:0];
    gl_len   = group_left_q | (byte_count_q[0] ? {6'b0, byte_i, 8'b0} : {14'b0, byte_i});

    unique case (phase_q)
      PH_GID_LO: begin
        assembly_d = {24'b0, byte_i};
        phase_d    = PH_GID_HI;
      end
      PH_GID_HI: begin
        group_base_d = word;
        phase_d      = PH_LEN0;
      end
      PH_LEN0: begin
        case (byte_i[7:6])
          pld_pkg::LEN_CODE_ERROR: fail = 1'b1;
          2'd0: begin
            group_left_d = {16'b0, byte_i[5:0]};
            if (byte_i[5:0] == 6'd0) fail = 1'b1;
            else phase_d = PH_ENT_LO;
          end
          default: begin
            group_left_d = byte_i[7] ? {byte_i[5:0], 16'b0} : {8'b0, byte_i[5:0], 8'b0};
            value_code_d = {1'b0, byte_i[7:6]};
            byte_count_d = 3'd0;
            phase_d      = PH_LEN_MORE;
          end
        endcase
      end
      PH_LEN_MORE: begin
        group_left_d = gl_len;
        byte_count_d = bc_inc;
        if (bc_inc >= value_code_q) begin
          if (gl_len == 22'd0) fail = 1'b1;
          else phase_d = PH_ENT_LO;
        end
      end
      PH_ENT_LO: begin
        group_left_d = gl_dec;
        assembly_d   = {24'b0, byte_i};
        if (gl_dec == 22'd0) fail = 1'b1;
        else phase_d = PH_ENT_HI;
      end
      PH_ENT_HI: begin
        group_left_d   = gl_dec;
        entry_low_id_d = {byte_i, assembly_q[7:4]};
        assembly_d     = '0;
        byte_count_d   = 3'd0;
        if (ent_code[3]) begin
          if (ent_code[2:0] == 3'd0) begin
            if (gl_dec == 22'd0) fail = 1'b1;
            else phase_d = PH_AREA_LEN;
          end else begin
            start    = 1'b1;
            area_cnt = {30'b0, ent_code[2:0]} + 33'd1;
          end
        end else if (ent_code[2:0] < 3'd5) begin
          have    = 1'b1;
          kind    = pld_pkg::KIND_FIXED;
          val     = {29'b0, ent_code[2:0]};
          phase_d = (gl_dec == 22'd0) ? PH_GID_LO : PH_ENT_LO;
        end else begin
          value_code_d = pld_pkg::value_size(ent_code[1:0]);
          if (gl_dec == 22'd0) fail = 1'b1;
          else phase_d = PH_FIX_VAL;
        end
      end
      PH_FIX_VAL: begin
        group_left_d = gl_dec;
        assembly_d   = asm_col;
        byte_count_d = bc_inc;
        if (bc_inc >= value_code_q) begin
          have    = 1'b1;
          kind    = pld_pkg::KIND_FIXED;
          val     = asm_col;
          phase_d = (gl_dec == 22'd0) ? PH_GID_LO : PH_ENT_LO;
        end else if (gl_dec == 22'd0) begin
          fail = 1'b1;
        end
      end
      PH_AREA_LEN: begin
        group_left_d = gl_dec;
        assembly_d   = asm_col;
        byte_count_d = bc_inc;
        if (bc_inc >= 3'd4) begin
          start    = 1'b1;
          area_cnt = {1'b0, asm_col} + 33'd1;
        end else if (gl_dec == 22'd0) begin
          fail = 1'b1;
        end
      end
      PH_POS_LO: begin
        group_left_d = gl_dec;
        area_left_d  = al_dec;
        assembly_d   = {24'b0, byte_i};
        if (al_dec == 33'd0) fail = 1'b1;
        else phase_d = PH_POS_HI;
      end
      PH_POS_HI: begin
        group_left_d = gl_dec;
        area_left_d  = al_dec;
        pos_hold_d   = word[13:0];
        assembly_d   = '0;
        byte_count_d = 3'd0;
        if (word[15:14] == 2'd0) begin
          have = 1'b1;
          kind = pld_pkg::KIND_POSITION;
          pos  = word[13:0];
          if (al_dec != 33'd0) phase_d = PH_POS_LO;
          else phase_d = (gl_dec == 22'd0) ? PH_GID_LO : PH_ENT_LO;
        end else begin
          value_code_d = pld_pkg::value_size(word[15:14]);
          if (al_dec == 33'd0) fail = 1'b1;
          else phase_d = PH_POS_VAL;
        end
      end
      PH_POS_VAL: begin
        group_left_d = gl_dec;
        area_left_d  = al_dec;
        assembly_d   = asm_col;
        byte_count_d = bc_inc;
        if (bc_inc >= value_code_q) begin
          have = 1'b1;
          kind = pld_pkg::KIND_POSITION;
          val  = asm_col;
          pos  = pos_hold_q;
          if (al_dec != 33'd0) phase_d = PH_POS_LO;
          else phase_d = (gl_dec == 22'd0) ? PH_GID_LO : PH_ENT_LO;
        end else if (al_dec == 33'd0) begin
          fail = 1'b1;
        end
      end
      PH_DRAIN: begin
        phase_d = PH_DRAIN;
      end
      default: begin
        phase_d = PH_GID_LO;
      end
    endcase

    // A position area may not reach past the end of its group.
    if (start) begin
      if (area_cnt > {11'b0, gl_dec}) begin
        fail = 1'b1;
      end else begin
        have        = 1'b1;
        kind        = pld_pkg::KIND_VAR_HDR;
        area        = area_cnt;
        area_left_d = area_cnt;
        phase_d     = PH_POS_LO;
      end
    end

    if (fail) begin
      have    = 1'b1;
      kind    = pld_pkg::KIND_ERROR;
      val     = '0;
      pos     = '0;
      area    = '0;
      phase_d = PH_DRAIN;
    end

    // End of list: while draining it only restarts the parser; otherwise the
    // list must end exactly on a group boundary.
    if (eol_i) begin
      if (phase_q != PH_DRAIN) begin
        if (!(have && (kind == pld_pkg::KIND_ERROR || phase_d == PH_GID_LO))) begin
          have = 1'b1;
          kind = pld_pkg::KIND_ERROR;
          val  = '0;
          pos  = '0;
          area = '0;
        end
      end
      phase_d = PH_GID_LO;
    end
  end

  always_comb begin
    res_o.have        = have;
    res_o.kind        = kind;
    res_o.doc_id      = (kind == pld_pkg::KIND_ERROR) ? 28'd0 : {group_base_d, entry_low_id_d};
    res_o.entry_value = val;
    res_o.position    = pos;
    res_o.area_bytes  = area;
    res_o.list_done   = eol_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q        <= PH_GID_LO;
      group_base_q   <= '0;
      group_left_q   <= '0;
      area_left_q    <= '0;
      assembly_q     <= '0;
      byte_count_q   <= '0;
      entry_low_id_q <= '0;
      value_code_q   <= '0;
      pos_hold_q     <= '0;
    end else if (step_i) begin
      phase_q        <= phase_d;
      group_base_q   <= group_base_d;
      group_left_q   <= group_left_d;
      area_left_q    <= area_left_d;
      assembly_q     <= assembly_d;
      byte_count_q   <= byte_count_d;
      entry_low_id_q <= entry_low_id_d;
      value_code_q   <= value_code_d;
      pos_hold_q     <= pos_hold_d;
    end
  end

  `PLD_ASSERT(a_eol_restarts, step_i && eol_i |=> phase_q == PH_GID_LO, "end of list did not restart the parser")
  `PLD_ASSERT(a_error_drains, step_i && have && kind == pld_pkg::KIND_ERROR && !eol_i |=> phase_q == PH_DRAIN, "format error did not enter drain")
  `PLD_ASSERT_NEVER(a_area_in_group, (phase_q == PH_POS_LO || phase_q == PH_POS_HI || phase_q == PH_POS_VAL) && (area_left_q > {11'b0, group_left_q}), "position area exceeds group body")

endmodule

`default_nettype wire

### tb/pld_stream_pkg.sv
// Posting list stream codes shared by the testbench stimulus and the record checker.
`timescale 1ns / 1ps

package pld_stream_pkg;

  // Top two bits of the first group length byte.
  localparam logic [1:0] LEN_SHORT = 2'd0;
  localparam logic [1:0] LEN_MID   = 2'd1;
  localparam logic [1:0] LEN_LONG  = 2'd2;

  // Value size codes of position words.
  localparam logic [1:0] VSZ_NONE = 2'd0;
  localparam logic [1:0] VSZ_BYTE = 2'd1;
  localparam logic [1:0] VSZ_HALF = 2'd2;
  localparam logic [1:0] VSZ_WORD = 2'd3;

  // Low nibble of a fixed entry word: inline values up to FIX_INLINE_MAX, then the
  // codes for one, two and four value bytes. Bit 3 marks a variable entry.
  localparam logic [3:0] FIX_INLINE_MAX = 4'd4;
  localparam logic [3:0] FIX_BYTE       = 4'd5;
  localparam logic [3:0] FIX_WORD       = 4'd7;
  localparam logic [3:0] ENTRY_VAR      = 4'b1000;

  function automatic logic [2:0] bytes_of_size(logic [1:0] sz);
    if (sz == VSZ_BYTE) begin
      return 3'd1;
    end else if (sz == VSZ_HALF) begin
      return 3'd2;
    end
    return 3'd4;
  endfunction

endpackage

### tb/pld_record_checker.sv
// Watches both channels of the posting list decoder, predicts every record and compares.
`timescale 1ns / 1ps

module pld_record_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  pld_in_if           byte_ch_i,
  pld_out_if          rec_ch_i,
  output int unsigned mismatches_o,
  output int unsigned pending_o,
  output int unsigned records_o
);

  typedef enum logic [3:0] {
    ST_GID_LO, ST_GID_HI, ST_LEN0, ST_LEN_MORE, ST_ENT_LO, ST_ENT_HI, ST_FIX_VAL,
    ST_AREA_LEN, ST_POS_LO, ST_POS_HI, ST_POS_VAL, ST_DRAIN
  } parse_state_e;

  parse_state_e parse_st;
  logic [15:0]  group_id;
  logic [21:0]  group_bytes;
  logic [32:0]  area_left;
  logic [31:0]  gather;
  logic [2:0]   gathered;
  logic [11:0]  low_id;
  logic [2:0]   need;
  logic [13:0]  held_pos;

  pld_pkg::pld_result_t next_rec;
  pld_pkg::pld_result_t expected_records [$];

  task automatic log_mismatch(input string msg);
    mismatches_o++;
    $display("[%0t] record %0d: %s", $time, records_o, msg);
  endtask

  task automatic post_record(input logic [1:0] kind, input logic [31:0] value,
                             input logic [13:0] pos, input logic [32:0] area);
    next_rec.have        = 1'b1;
    next_rec.kind        = kind;
    next_rec.entry_value = value;
    next_rec.position    = pos;
    next_rec.area_bytes  = area;
  endtask

  task automatic flag_error();
    post_record(pld_pkg::KIND_ERROR, '0, '0, '0);
    parse_st = ST_DRAIN;
  endtask

  task automatic after_entry();
    parse_st = (group_bytes == 0) ? ST_GID_LO : ST_ENT_LO;
  endtask

  task automatic after_position();
    if (area_left == 0) after_entry();
    else parse_st = ST_POS_LO;
  endtask

  task automatic open_area(input logic [32:0] count);
    if (count > 33'(group_bytes)) begin
      flag_error();
    end else begin
      post_record(pld_pkg::KIND_VAR_HDR, '0, '0, count);
      area_left = count;
      parse_st  = ST_POS_LO;
    end
  endtask

  task automatic take_byte(input logic [7:0] b);
    gather   = gather | (32'(b) << (8 * gathered[1:0]));
    gathered = gathered + 3'd1;
  endtask

  function automatic logic gather_done(logic [2:0] got, logic [2:0] wanted);
    return got >= wanted;
  endfunction

  // One stream byte through the parser; next_rec.have tells whether it makes a record.
  task automatic parse_byte(input logic [7:0] b, input logic eol);
    logic [3:0]  code4;
    logic [15:0] word;
    next_rec = '0;
    if (parse_st == ST_DRAIN) begin
      if (eol) parse_st = ST_GID_LO;
    end else begin
      case (parse_st)
        ST_GID_LO: begin
          gather   = 32'(b);
          parse_st = ST_GID_HI;
        end
        ST_GID_HI: begin
          group_id = {b, gather[7:0]};
          parse_st = ST_LEN0;
        end
        ST_LEN0: begin
          if (b[7:6] == pld_pkg::LEN_CODE_ERROR) begin
            flag_error();
          end else if (b[7:6] == pld_stream_pkg::LEN_SHORT) begin
            group_bytes = 22'(b[5:0]);
            if (group_bytes == 0) flag_error();
            else parse_st = ST_ENT_LO;
          end else begin
            group_bytes = 22'(b[5:0]) << (8 * b[7:6]);
            need        = 3'(b[7:6]);
            gathered    = '0;
            parse_st    = ST_LEN_MORE;
          end
        end
        ST_LEN_MORE: begin
          group_bytes = group_bytes | (22'(b) << (8 * gathered[0]));
          gathered    = gathered + 3'd1;
          if (gathered >= need) begin
            if (group_bytes == 0) flag_error();
            else parse_st = ST_ENT_LO;
          end
        end
        ST_ENT_LO: begin
          group_bytes = group_bytes - 22'd1;
          gather      = 32'(b);
          if (group_bytes == 0) flag_error();
          else parse_st = ST_ENT_HI;
        end
        ST_ENT_HI: begin
          group_bytes = group_bytes - 22'd1;
          low_id      = {b, gather[7:4]};
          code4       = gather[3:0];
          gather      = '0;
          gathered    = '0;
          if (code4[3]) begin
            // A zero area code means the area length follows as a 32-bit word.
            if (code4[2:0] == 3'd0) begin
              if (group_bytes == 0) flag_error();
              else parse_st = ST_AREA_LEN;
            end else begin
              open_area(33'(code4[2:0]) + 33'd1);
            end
          end else if (code4 <= pld_stream_pkg::FIX_INLINE_MAX) begin
            post_record(pld_pkg::KIND_FIXED, 32'(code4), '0, '0);
            after_entry();
          end else begin
            need = pld_stream_pkg::bytes_of_size(
                     2'(code4 - pld_stream_pkg::FIX_INLINE_MAX));
            if (group_bytes == 0) flag_error();
            else parse_st = ST_FIX_VAL;
          end
        end
        ST_FIX_VAL: begin
          group_bytes = group_bytes - 22'd1;
          take_byte(b);
          if (gathered >= need) begin
            post_record(pld_pkg::KIND_FIXED, gather, '0, '0);
            after_entry();
          end else if (group_bytes == 0) begin
            flag_error();
          end
        end
        ST_AREA_LEN: begin
          group_bytes = group_bytes - 22'd1;
          take_byte(b);
          if (gathered >= 3'd4) open_area(33'(gather) + 33'd1);
          else if (group_bytes == 0) flag_error();
        end
        ST_POS_LO: begin
          group_bytes = group_bytes - 22'd1;
          area_left   = area_left - 33'd1;
          gather      = 32'(b);
          if (area_left == 0) flag_error();
          else parse_st = ST_POS_HI;
        end
        ST_POS_HI: begin
          group_bytes = group_bytes - 22'd1;
          area_left   = area_left - 33'd1;
          word        = {b, gather[7:0]};
          held_pos    = word[13:0];
          gather      = '0;
          gathered    = '0;
          if (word[15:14] == pld_stream_pkg::VSZ_NONE) begin
            post_record(pld_pkg::KIND_POSITION, '0, held_pos, '0);
            after_position();
          end else begin
            need = pld_stream_pkg::bytes_of_size(word[15:14]);
            if (area_left == 0) flag_error();
            else parse_st = ST_POS_VAL;
          end
        end
        default: begin
          group_bytes = group_bytes - 22'd1;
          area_left   = area_left - 33'd1;
          take_byte(b);
          if (gather_done(gathered, need)) begin
            post_record(pld_pkg::KIND_POSITION, gather, held_pos, '0);
            after_position();
          end else if (area_left == 0) begin
            flag_error();
          end
        end
      endcase
      // The last byte of a list must close a group; otherwise it reports an error.
      if (eol) begin
        if (!(next_rec.have &&
              (next_rec.kind == pld_pkg::KIND_ERROR || parse_st == ST_GID_LO)))
          post_record(pld_pkg::KIND_ERROR, '0, '0, '0);
        parse_st = ST_GID_LO;
      end
      next_rec.doc_id    = (next_rec.kind == pld_pkg::KIND_ERROR) ? '0 : {group_id, low_id};
      next_rec.list_done = eol;
    end
  endtask

  task automatic compare_field(input string name, input logic [32:0] seen,
                               input logic [32:0] want);
    if (seen !== want) log_mismatch($sformatf("%s is %h, expected %h", name, seen, want));
  endtask

  always @(posedge clk_i) begin
    pld_pkg::pld_result_t seen;
    pld_pkg::pld_result_t want;
    if (!rst_ni) begin
      parse_st    = ST_GID_LO;
      group_id    = '0;
      group_bytes = '0;
      area_left   = '0;
      gather      = '0;
      gathered    = '0;
      low_id      = '0;
      need        = '0;
      held_pos    = '0;
      expected_records.delete();
    end else begin
      if (rec_ch_i.valid && rec_ch_i.ready) begin
        records_o++;
        seen             = '0;
        seen.kind        = rec_ch_i.kind;
        seen.doc_id      = rec_ch_i.doc_id;
        seen.entry_value = rec_ch_i.entry_value;
        seen.position    = rec_ch_i.position;
        seen.area_bytes  = rec_ch_i.area_bytes;
        seen.list_done   = rec_ch_i.list_done;
        if (expected_records.size() == 0) begin
          log_mismatch($sformatf("unexpected record, kind %0d doc_id %h",
                                 seen.kind, seen.doc_id));
        end else begin
          want = expected_records.pop_front();
          compare_field("kind", 33'(seen.kind), 33'(want.kind));
          compare_field("doc_id", 33'(seen.doc_id), 33'(want.doc_id));
          compare_field("entry_value", 33'(seen.entry_value), 33'(want.entry_value));
          compare_field("position", 33'(seen.position), 33'(want.position));
          compare_field("area_bytes", seen.area_bytes, want.area_bytes);
          compare_field("list_done", 33'(seen.list_done), 33'(want.list_done));
        end
      end
      if (byte_ch_i.valid && byte_ch_i.ready) begin
        parse_byte(byte_ch_i.data_byte, byte_ch_i.end_of_list);
        if (next_rec.have) expected_records.push_back(next_rec);
      end
    end
    pending_o <= expected_records.size();
  end

endmodule

### tb/tb.sv
// Testbench top of the posting list decoder: clock, reset, byte stream, record stalls, verdict.
`timescale 1ns / 1ps

module tb;

  localparam int STREAM_BYTES = 560;

  // Hand-made lists, each beat as {end_of_list, data_byte}: a length code of three,
  // an empty group followed by skipped bytes, extreme ids with inline and 32-bit
  // values, and a variable entry whose position carries a two-byte value.
  localparam logic [8:0] DIRECTED [27] = '{
    9'h0FF, 9'h0FF, 9'h1C0,
    9'h000, 9'h000, 9'h000, 9'h155,
    9'h0FF, 9'h0FF, 9'h008, 9'h0F4, 9'h0FF, 9'h007, 9'h000, 9'h000, 9'h000, 9'h000,
    9'h180,
    9'h001, 9'h000, 9'h006, 9'h01B, 9'h000, 9'h0FF, 9'h0BF, 9'h0FF, 9'h1FF
  };

  logic        clk;
  logic        rst_n;
  int unsigned mismatches;
  int unsigned pending;
  int unsigned records;
  int          intact_lists;
  int          damaged_lists;
  logic [8:0]  stream [$];
  logic [7:0]  list_q [$];

  pld_in_if  byte_ch ();
  pld_out_if rec_ch ();

  posting_list_decoder i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (byte_ch),
    .out_o  (rec_ch)
  );

  pld_record_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .byte_ch_i    (byte_ch),
    .rec_ch_i     (rec_ch),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .records_o    (records)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  task automatic put_le(input logic [31:0] v, input int n);
    for (int i = 0; i < n; i++) list_q.push_back(v[8*i +: 8]);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int         word_at;
    int         area_len;
    int         len_at;
    int         len;
    int         pick;
    int         keep;
    int         gap;
    int         burst;
    int         k;
    logic [11:0] low;
    logic [3:0]  code;
    logic [1:0]  lc;
    logic [1:0]  sz;

    rst_n                <= 1'b0;
    byte_ch.valid        <= 1'b0;
    byte_ch.data_byte    <= '0;
    byte_ch.end_of_list  <= 1'b0;
    intact_lists  = 0;
    damaged_lists = 0;

    foreach (DIRECTED[i]) stream.push_back(DIRECTED[i]);
    while (stream.size() < $size(DIRECTED) + STREAM_BYTES) begin
      list_q.delete();
      repeat ($urandom_range(1, 2)) begin
        put_le($urandom(), 2);
        len_at = list_q.size();
        repeat ($urandom_range(1, 3)) begin
          low     = 12'($urandom());
          word_at = list_q.size();
          pick    = $urandom_range(0, 2);
          if (pick == 0) begin
            code = 4'($urandom_range(0, pld_stream_pkg::FIX_INLINE_MAX));
            put_le({16'h0, low, code}, 2);
          end else if (pick == 1) begin
            code = 4'($urandom_range(pld_stream_pkg::FIX_BYTE, pld_stream_pkg::FIX_WORD));
            put_le({16'h0, low, code}, 2);
            put_le(pick_value(), int'(pld_stream_pkg::bytes_of_size(
                                   2'(code - pld_stream_pkg::FIX_INLINE_MAX))));
          end else begin
            put_le({16'h0, low, pld_stream_pkg::ENTRY_VAR}, 2);
            repeat ($urandom_range(1, 2)) begin
              sz = 2'($urandom_range(0, 3));
              put_le({16'h0, sz, 14'($urandom())}, 2);
              if (sz != pld_stream_pkg::VSZ_NONE)
                put_le(pick_value(), int'(pld_stream_pkg::bytes_of_size(sz)));
            end
            // Short areas may use the inline length; otherwise a 32-bit length follows.
            area_len = list_q.size() - word_at - 2;
            if (area_len <= 8 && $urandom_range(0, 2) != 0) begin
              list_q[word_at] = list_q[word_at] | 8'(area_len - 1);
            end else begin
              for (int i = 3; i >= 0; i--)
                list_q.insert(word_at + 2, 8'((area_len - 1) >> (8 * i)));
            end
          end
        end
        len = list_q.size() - len_at;
        if (len < 64) lc = 2'($urandom_range(0, 2));
        else lc = 2'($urandom_range(1, 2));
        case (lc)
          pld_stream_pkg::LEN_SHORT: begin
            list_q.insert(len_at, {pld_stream_pkg::LEN_SHORT, 6'(len)});
          end
          pld_stream_pkg::LEN_MID: begin
            list_q.insert(len_at, 8'(len));
            list_q.insert(len_at, {pld_stream_pkg::LEN_MID, 6'(len >> 8)});
          end
          default: begin
            list_q.insert(len_at, 8'(len >> 8));
            list_q.insert(len_at, 8'(len));
            list_q.insert(len_at, {pld_stream_pkg::LEN_LONG, 6'(len >> 16)});
          end
        endcase
      end
      // Most lists go out intact; the rest are cut short, get one byte
      // overwritten, or are replaced by random bytes.
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        intact_lists++;
      end else begin
        damaged_lists++;
        if (pick == 7) begin
          keep = $urandom_range(1, list_q.size() - 1);
          while (list_q.size() > keep) void'(list_q.pop_back());
        end else if (pick == 8) begin
          list_q[$urandom_range(0, list_q.size() - 1)] = 8'($urandom());
        end else begin
          list_q.delete();
          repeat ($urandom_range(1, 8)) list_q.push_back(8'($urandom()));
        end
      end
      foreach (list_q[i]) stream.push_back({1'(i == list_q.size() - 1), list_q[i]});
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    k = 0;
    while (k < stream.size()) begin
      burst = $urandom_range(1, 32);
      while (burst > 0 && k < stream.size()) begin
        byte_ch.valid       <= 1'b1;
        byte_ch.data_byte   <= stream[k][7:0];
        byte_ch.end_of_list <= stream[k][8];
        do @(posedge clk); while (!byte_ch.ready);
        k++;
        burst--;
      end
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        byte_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    byte_ch.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Streamed %0d bytes: the hand-made lists, %0d well-formed lists and %0d damaged",
             stream.size(), intact_lists, damaged_lists);
    $display("or noise sequences; %0d records checked under random and long output stalls.",
             records);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Record side: the stall pattern is redrawn at random among four modes, and twice the receiver
  // holds off long enough for both decoder stages to fill and input ready to drop.
  initial begin
    int cyc;
    int hold;
    int mode;
    cyc  = 0;
    hold = 0;
    mode = 0;
    rec_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc % 64 == 0) mode = $urandom_range(0, 3);
      if (cyc == 250 || cyc == 700) hold = 90;
      if (hold > 0) begin
        hold--;
        rec_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0:       rec_ch.ready <= 1'b1;
          1:       rec_ch.ready <= cyc[0];
          2:       rec_ch.ready <= 1'($urandom_range(0, 1));
          default: rec_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d records still expected.", pending);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/pld_pkg.sv
hw/rtl/pld_if.sv
hw/rtl/pld_core.sv
hw/rtl/posting_list_decoder.sv
tb/pld_stream_pkg.sv
tb/pld_record_checker.sv
tb/tb.sv
